@@ design/frr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types, codes and helpers of the first match route resolver.
// ----------------------------------------------------------------------------
package frr_pkg;

  // Width of an IPv4 address word.
  localparam int unsigned AddrW = 32;

  // Item kinds carried on the action field.
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LOCAL_IP   = 2'd0;
  localparam logic [1:0] CFG_LOCAL_PLEN = 2'd1;
  localparam logic [1:0] CFG_ROUTE_CNT  = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ROUTE = 2'd1,
    STATUS_HOPS     = 2'd2,
    STATUS_BAD_MASK = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOP,
    ST_SCAN
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [AddrW-1:0] dest;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] hop;
  } route_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [AddrW-1:0] local_ip;
    logic [5:0]       local_prefix_len;
    logic [5:0]       route_count;
  } cfg_t;

  // Mask of the top len bits; lengths of 32 and above give all ones.
  function automatic logic [AddrW-1:0] mask_of_len(input logic [5:0] len);
    mask_of_len = ~({AddrW{1'b1}} >> len);
  endfunction

endpackage

@@ design/first_match_route_resolver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_match_route_resolver
// IPv4 route table with first match lookup and recursive next hop walk.
// ----------------------------------------------------------------------------
// A write item's result appears in the next cycle and a new item may be
// started right away. A resolve item walks the table one hop at a time.
// Each hop first checks the local route and, when that misses, scans the
// table entry by entry; the single read port of the route memory delivers
// one entry per cycle. At most MAX_HOPS hops are followed, and the scan
// ends at the last entry, route_count clamped to MAX_ROUTES - 1. Each
// result is shown for one cycle with done_o high and is not held: the
// receiver must take it in that cycle. Configuration writes are always
// taken and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module first_match_route_resolver import frr_pkg::*; #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned MAX_HOPS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [5:0]  route_slot_i,
  input  logic [31:0] route_dest_i,
  input  logic [5:0]  route_prefix_len_i,
  input  logic [31:0] route_next_hop_i,
  input  logic [31:0] query_ip_i,
  // Result channel.
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] resolved_ip_o,
  output logic [3:0]  hops_taken_o
);

  localparam int unsigned AW = $clog2(MAX_ROUTES);

  cfg_t            cfg_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  route_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  route_t          mem_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOCAL_IP:   cfg_q.local_ip         <= cfg_data_i;
        CFG_LOCAL_PLEN: cfg_q.local_prefix_len <= cfg_data_i[5:0];
        CFG_ROUTE_CNT:  cfg_q.route_count      <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // Lookup and load sequencer.
  frr_walker #(
    .MAX_ROUTES (MAX_ROUTES),
    .MAX_HOPS   (MAX_HOPS)
  ) u_walker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .route_slot_i       (route_slot_i),
    .route_dest_i       (route_dest_i),
    .route_prefix_len_i (route_prefix_len_i),
    .route_next_hop_i   (route_next_hop_i),
    .query_ip_i         (query_ip_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .resolved_ip_o      (resolved_ip_o),
    .hops_taken_o       (hops_taken_o),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_re_o           (mem_re),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata)
  );

  // Route storage.
  frr_route_mem #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_route_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

@@ design/frr_route_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_route_mem
// Route storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frr_route_mem import frr_pkg::*; #(
  parameter int unsigned MAX_ROUTES = 64
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MAX_ROUTES)-1:0] waddr_i,
  input  route_t                        wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(MAX_ROUTES)-1:0] raddr_i,
  output route_t                        rdata_o
);

  route_t mem_q [MAX_ROUTES];
  route_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/frr_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frr_walker
// Item sequencer: loads routes and walks the table hop by hop for lookups.
// ----------------------------------------------------------------------------
module frr_walker import frr_pkg::*; #(
  parameter int unsigned MAX_ROUTES = 64,
  parameter int unsigned MAX_HOPS   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [5:0]                    route_slot_i,
  input  logic [31:0]                   route_dest_i,
  input  logic [5:0]                    route_prefix_len_i,
  input  logic [31:0]                   route_next_hop_i,
  input  logic [31:0]                   query_ip_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [31:0]                   resolved_ip_o,
  output logic [3:0]                    hops_taken_o,
  output logic                          mem_we_o,
  output logic [$clog2(MAX_ROUTES)-1:0] mem_waddr_o,
  output route_t                        mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(MAX_ROUTES)-1:0] mem_raddr_o,
  input  route_t                        mem_rdata_i
);

  localparam int unsigned AW = $clog2(MAX_ROUTES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = (AW > 6) ? AW : 6;
  localparam int unsigned HW = $clog2(MAX_HOPS + 1);
  localparam int unsigned XW = (HW > 4) ? HW : 4;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  ip_q, ip_d;
  logic [HW-1:0]     hops_q, hops_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic              pend_q, pend_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [AddrW-1:0]  res_ip_q, res_ip_d;
  logic [3:0]        hops_out_q, hops_out_d;

  logic [SW-1:0]     slot_ext;
  logic              slot_ok;
  logic [AddrW-1:0]  wr_mask;
  logic              dest_ok;
  logic [CW-1:0]     last;
  logic [AddrW-1:0]  local_mask;
  logic              local_hit;
  logic              issue;
  logic              entry_hit;
  logic              scan_hit;
  logic              scan_miss_end;
  logic              limit_hit;
  logic              follow;
  logic [XW-1:0]     hops_ext;

  // Write item checks: slot range and destination bits outside the mask.
  assign slot_ext = SW'(route_slot_i);
  assign slot_ok  = (route_slot_i != '0) && (int'(route_slot_i) < int'(MAX_ROUTES));
  assign wr_mask  = mask_of_len(route_prefix_len_i);
  assign dest_ok  = ((route_dest_i & wr_mask) == route_dest_i);

  // Last entry to scan, clamped to the table depth.
  assign last = (int'(cfg_i.route_count) > int'(MAX_ROUTES - 1)) ?
                CW'(MAX_ROUTES - 1) : CW'(cfg_i.route_count);

  // The local network route is held in registers and checked directly.
  assign local_mask = mask_of_len(cfg_i.local_prefix_len);
  assign local_hit  = ((cfg_i.local_ip & local_mask) == (ip_q & local_mask));

  // Scan pipeline: one read issued per cycle, compared in the next cycle.
  assign issue         = (addr_q <= last);
  assign entry_hit     = (mem_rdata_i.dest == (ip_q & mem_rdata_i.mask));
  assign scan_hit      = pend_q && entry_hit;
  assign scan_miss_end = pend_q && !entry_hit && !issue;
  assign limit_hit     = (hops_q >= HW'(MAX_HOPS));
  assign follow        = (mem_rdata_i.hop != '0) && !limit_hit;

  assign hops_ext = XW'(hops_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (action_i == ACT_RESOLVE)) begin
          state_d = ST_HOP;
        end
      end
      ST_HOP: begin
        if (local_hit || (last == '0)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = follow ? ST_HOP : ST_IDLE;
        end else if (scan_miss_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ip_d       = ip_q;
    hops_d     = hops_q;
    addr_d     = addr_q;
    pend_d     = 1'b0;
    done_d     = 1'b0;
    status_d   = status_q;
    res_ip_d   = res_ip_q;
    hops_out_d = hops_out_q;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_WRITE) begin
            done_d     = 1'b1;
            res_ip_d   = '0;
            hops_out_d = '0;
            status_d   = (slot_ok && !dest_ok) ? STATUS_BAD_MASK : STATUS_OK;
            mem_we_o   = slot_ok && dest_ok;
          end else begin
            ip_d   = query_ip_i;
            hops_d = '0;
          end
        end
      end
      ST_HOP: begin
        // The local route is always direct.
        if (local_hit || (last == '0)) begin
          done_d     = 1'b1;
          status_d   = local_hit ? STATUS_OK : STATUS_NO_ROUTE;
          res_ip_d   = ip_q;
          hops_out_d = hops_ext[3:0];
        end else begin
          addr_d = CW'(1);
        end
      end
      ST_SCAN: begin
        mem_re_o = issue;
        addr_d   = addr_q + CW'(1);
        pend_d   = issue;
        if (scan_hit) begin
          pend_d = 1'b0;
          if (follow) begin
            ip_d   = mem_rdata_i.hop;
            hops_d = hops_q + HW'(1);
          end else begin
            done_d     = 1'b1;
            status_d   = (mem_rdata_i.hop == '0) ? STATUS_OK : STATUS_HOPS;
            res_ip_d   = ip_q;
            hops_out_d = hops_ext[3:0];
          end
        end else if (scan_miss_end) begin
          done_d     = 1'b1;
          status_d   = STATUS_NO_ROUTE;
          res_ip_d   = ip_q;
          hops_out_d = hops_ext[3:0];
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ip_q       <= ip_d;
    hops_q     <= hops_d;
    addr_q     <= addr_d;
    status_q   <= status_d;
    res_ip_q   <= res_ip_d;
    hops_out_q <= hops_out_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign resolved_ip_o = res_ip_q;
  assign hops_taken_o  = hops_out_q;

  // Writes happen only between lookups, so a read never meets a write.
  assign mem_waddr_o       = slot_ext[AW-1:0];
  assign mem_wdata_o.dest  = route_dest_i;
  assign mem_wdata_o.mask  = wr_mask;
  assign mem_wdata_o.hop   = route_next_hop_i;
  assign mem_raddr_o       = addr_q[AW-1:0];

  // The table is never written while a lookup is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we_o |-> !busy)
    else $error("route write during a lookup");

  // Read and write ports are never active together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we_o && mem_re_o))
    else $error("route read and write in the same cycle");

  // An accepted lookup keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_RESOLVE)) |=> busy)
    else $error("lookup accepted without going busy");

  // A hop limit result always reports the full hop budget.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STATUS_HOPS)) |-> (hops_taken_o == 4'(MAX_HOPS)))
    else $error("hop limit result with wrong hop count");

  // The hop counter never passes the budget while walking.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (hops_q <= HW'(MAX_HOPS)))
    else $error("hop counter beyond the budget");

endmodule
